// File: hdl/bitmap_message_pool_allocator_top_defines.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_MESSAGE_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_MESSAGE_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BMPA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BMPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bmpa_pkg.sv
// Types, operation codes and bit-scan helpers for the slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package bmpa_pkg;

  localparam int MaxSlots = 32;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_STATS = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [4:0] slot_index;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [4:0]  slot;
    logic [5:0]  free_count;
    logic [5:0]  peak_busy;
    logic [31:0] fail_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] free_bits;
    logic [5:0]  peak_in_use;
    logic [31:0] fail_count;
  } pool_state_t;

  function automatic logic [5:0] count_ones32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

  // Lowest set bit; 0 when none is set.
  function automatic logic [4:0] lowest_set32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bmpa_ops.sv
// Next pool state and result word for one request, from the current state.
`timescale 1ns / 1ps
`default_nettype none
module bmpa_ops #(
  parameter int POOL_SLOTS = 32
) (
  input  bmpa_pkg::req_t        req,
  input  bmpa_pkg::pool_state_t cur,
  output bmpa_pkg::pool_state_t nxt,
  output bmpa_pkg::rsp_t        rsp
);
  import bmpa_pkg::*;

  localparam logic [31:0] PoolMask  = 32'((64'd1 << POOL_SLOTS) - 64'd1);
  localparam logic [5:0]  PoolCount = 6'(POOL_SLOTS);

  logic [31:0] avail;
  logic [4:0]  low_idx;
  logic [31:0] alloc_bits;
  logic [5:0]  alloc_used;

  assign avail      = cur.free_bits & PoolMask;
  assign low_idx    = lowest_set32(avail);
  assign alloc_bits = cur.free_bits & ~(32'd1 << low_idx);
  assign alloc_used = PoolCount - count_ones32(alloc_bits & PoolMask);

  always_comb begin
    nxt         = cur;
    rsp.granted = 1'b0;
    rsp.slot    = '0;
    case (req.func)
      FUNC_ALLOC: begin
        if (avail != '0) begin
          nxt.free_bits = alloc_bits;
          if (alloc_used > cur.peak_in_use) begin
            nxt.peak_in_use = alloc_used;
          end
          rsp.granted = 1'b1;
          rsp.slot    = low_idx;
        end else begin
          nxt.fail_count = cur.fail_count + 32'd1;
        end
      end
      FUNC_FREE: begin
        if ({1'b0, req.slot_index} < PoolCount) begin
          nxt.free_bits = cur.free_bits | (32'd1 << req.slot_index);
        end
      end
      FUNC_CLEAR: begin
        nxt.free_bits   = PoolMask;
        nxt.peak_in_use = '0;
        nxt.fail_count  = '0;
      end
      default: begin
      end
    endcase
    rsp.free_count = count_ones32(nxt.free_bits & PoolMask);
    rsp.peak_busy  = nxt.peak_in_use;
    rsp.fail_total = nxt.fail_count;
  end

endmodule
`default_nettype wire

// File: hdl/bitmap_message_pool_allocator_top.sv
// Top level of the bitmap message slot allocator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request word per cycle and returns one result word per request:
// the request register feeds the lowest-free-slot encoder and the 32-bit
// population count of the free bitmap, which resolve into the result
// register. The input stalls only while a result word waits unread and a
// second request is already held. The pool state updates as each request
// passes into the result register, so back-to-back requests see each
// other's effects. Reset and the clear request mark slots 0 to POOL_SLOTS-1
// free.
module bitmap_message_pool_allocator_top #(
  parameter int POOL_SLOTS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire bmpa_pkg::req_t in_word,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      bmpa_pkg::rsp_t out_word
);
  import bmpa_pkg::*;

  localparam logic [31:0] PoolMask  = 32'((64'd1 << POOL_SLOTS) - 64'd1);
  localparam logic [5:0]  PoolCount = 6'(POOL_SLOTS);

  logic        req_vld_r;
  req_t        req_r;
  logic        out_vld_r;
  rsp_t        rsp_r;
  pool_state_t state_r;
  pool_state_t state_nxt;
  rsp_t        rsp_nxt;
  logic        adv;

  // Result register frees up when empty or being taken.
  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = !req_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_word  = rsp_r;

  bmpa_ops #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_ops (
    .req(req_r),
    .cur(state_r),
    .nxt(state_nxt),
    .rsp(rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      state_r.free_bits   <= PoolMask;
      state_r.peak_in_use <= '0;
      state_r.fail_count  <= '0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= req_vld_r;
        if (req_vld_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_word;
    end
    if (adv && req_vld_r) begin
      rsp_r <= rsp_nxt;
    end
  end

`include "bitmap_message_pool_allocator_top_defines.svh"

  `BMPA_ASSERT_ALWAYS(a_no_slot_outside_pool, (state_r.free_bits & ~PoolMask) == '0, "free bit set beyond pool")
  `BMPA_ASSERT_ALWAYS(a_granted_slot_taken, !(out_vld_r && rsp_r.granted) || !state_r.free_bits[rsp_r.slot], "granted slot still marked free")
  `BMPA_ASSERT_ALWAYS(a_count_matches_map, !out_vld_r || (rsp_r.free_count == count_ones32(state_r.free_bits)), "free count disagrees with bitmap")
  `BMPA_ASSERT_ALWAYS(a_peak_covers_use, state_r.peak_in_use >= (PoolCount - count_ones32(state_r.free_bits)), "peak below current use")
  `BMPA_ASSERT_NEXT(a_clear_zeroes_stats, adv && req_vld_r && (req_r.func == FUNC_CLEAR), (state_r.fail_count == '0) && (state_r.peak_in_use == '0), "clear left stats")

endmodule
`default_nettype wire
